// ===== sv/pcmrq_pkg.sv =====
`timescale 1ns / 1ps

package pcmrq_pkg;

  localparam int DEF_CLIENTS     = 4;
  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int DEF_MAX_FRAME   = 64;

  localparam int LEN_W      = 7;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_POP   = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NO_OPEN = 2'd3;

  typedef struct packed {
    logic [1:0]       req;
    logic [1:0]       client;
    logic             client_ok;
    logic             len_ok;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
  } cmd_t;

endpackage

// ===== sv/pcmrq_if.sv =====
`timescale 1ns / 1ps

interface pcmrq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] client;
  logic [7:0] msg_len;
  logic [7:0] data_byte;

  modport source (output valid, req_type, client, msg_len, data_byte, input ready);
  modport sink (input valid, req_type, client, msg_len, data_byte, output ready);
endinterface

interface pcmrq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] client_out;
  logic [7:0] out_byte;
  logic [6:0] out_len;
  logic       last;
  logic       notify;
  logic       dropped_oldest;

  modport source (output valid, status, client_out, out_byte, out_len, last, notify,
                  dropped_oldest, input ready);
  modport sink (input valid, status, client_out, out_byte, out_len, last, notify,
                dropped_oldest, output ready);
endinterface

// ===== sv/pcmrq_ram.sv =====
`timescale 1ns / 1ps

module pcmrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pcmrq_front.sv =====
`timescale 1ns / 1ps

module pcmrq_front #(
  parameter int CLIENTS   = pcmrq_pkg::DEF_CLIENTS,
  parameter int MAX_FRAME = pcmrq_pkg::DEF_MAX_FRAME
) (
  input  logic              clk,
  input  logic              rst_n,
  pcmrq_in_if.sink          in_ch,
  output logic              cmd_valid,
  output pcmrq_pkg::cmd_t   cmd,
  input  logic              cmd_pop
);

  localparam int PW = (pcmrq_pkg::CMDQ_DEPTH > 1) ? $clog2(pcmrq_pkg::CMDQ_DEPTH) : 1;

  pcmrq_pkg::cmd_t q_r [pcmrq_pkg::CMDQ_DEPTH];
  pcmrq_pkg::cmd_t cls;
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            push;

  always_comb begin
    cls.req       = in_ch.req_type;
    cls.client    = in_ch.client;
    cls.client_ok = 5'(in_ch.client) < 5'(CLIENTS);
    cls.len_ok    = in_ch.msg_len <= 8'(MAX_FRAME);
    cls.len       = pcmrq_pkg::LEN_W'(in_ch.msg_len);
    cls.data      = in_ch.data_byte;
  end

  assign in_ch.ready = cnt_r != (PW + 1)'(pcmrq_pkg::CMDQ_DEPTH);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = cnt_r != '0;
  assign cmd         = q_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(pcmrq_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (cmd_pop) begin
      rd_nxt = (rd_r == PW'(pcmrq_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + (PW + 1)'(1);
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - (PW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cls;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/pcmrq_back.sv =====
`timescale 1ns / 1ps

module pcmrq_back #(
  parameter int CLIENTS     = pcmrq_pkg::DEF_CLIENTS,
  parameter int QUEUE_DEPTH = pcmrq_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_FRAME   = pcmrq_pkg::DEF_MAX_FRAME
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  pcmrq_pkg::cmd_t   cmd,
  output logic              cmd_pop,
  pcmrq_out_if.source       out_ch
);

  localparam int SLOTS = CLIENTS * QUEUE_DEPTH;
  localparam int BYTES = SLOTS * MAX_FRAME;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW    = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int CIW   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int QIW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LW    = pcmrq_pkg::LEN_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_BYTES
  } state_t;

  function automatic logic [SW-1:0] slot_index(input logic [CIW-1:0] ci,
                                               input logic [QIW-1:0] s);
    return SW'(ci) * SW'(QUEUE_DEPTH) + SW'(s);
  endfunction

  function automatic logic [AW-1:0] slot_base(input logic [SW-1:0] si);
    return AW'(si) * AW'(MAX_FRAME);
  endfunction

  function automatic logic [QIW-1:0] ring_inc(input logic [QIW-1:0] h);
    return (h == QIW'(QUEUE_DEPTH - 1)) ? '0 : h + QIW'(1);
  endfunction

  state_t           state_r, state_nxt;
  logic [QIW-1:0]   head_r [CLIENTS];
  logic [QIW-1:0]   head_nxt [CLIENTS];
  logic [CNTW-1:0]  count_r [CLIENTS];
  logic [CNTW-1:0]  count_nxt [CLIENTS];
  logic             open_flag_r, open_flag_nxt;
  logic [1:0]       open_client_r, open_client_nxt;
  logic [LW-1:0]    open_length_r, open_length_nxt;
  logic [LW-1:0]    open_received_r, open_received_nxt;
  logic [QIW-1:0]   open_slot_r, open_slot_nxt;
  logic [1:0]       pop_client_r, pop_client_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [LW-1:0]    idx_r, idx_nxt;
  logic [LW-1:0]    mlen_r, mlen_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_client_r;
  logic [7:0]       out_byte_r;
  logic [LW-1:0]    out_len_r;
  logic             out_last_r, out_notify_r, out_drop_r;

  logic             out_free, emit;
  logic [1:0]       e_status, e_client;
  logic [7:0]       e_byte;
  logic [LW-1:0]    e_len;
  logic             e_last, e_notify, e_drop;

  logic             byte_we, byte_re;
  logic [AW-1:0]    byte_waddr, byte_raddr;
  logic [7:0]       byte_rdata;
  logic             len_we, len_re;
  logic [SW-1:0]    len_waddr, len_raddr;
  logic [LW-1:0]    len_wdata, len_rdata, mlen_cap;

  logic [CIW-1:0]   cidx, ocidx;
  logic [QIW-1:0]   h, h1, slot;
  logic [CNTW-1:0]  c, c1;
  logic [QIW:0]     slot_sum;
  logic             full;
  logic [LW-1:0]    recv_inc;

  assign out_free = !out_valid_r || out_ch.ready;
  assign cidx     = CIW'(cmd.client);
  assign ocidx    = CIW'(open_client_r);
  assign h        = head_r[cidx];
  assign c        = count_r[cidx];
  assign full     = c >= CNTW'(QUEUE_DEPTH);
  assign h1       = full ? ring_inc(h) : h;
  assign c1       = full ? c - CNTW'(1) : c;
  assign slot_sum = (QIW + 1)'(h1) + (QIW + 1)'(c1);
  assign slot     = (slot_sum >= (QIW + 1)'(QUEUE_DEPTH)) ?
                    QIW'(slot_sum - (QIW + 1)'(QUEUE_DEPTH)) : QIW'(slot_sum);
  assign recv_inc = open_received_r + LW'(1);
  assign mlen_cap = (len_rdata > LW'(MAX_FRAME)) ? LW'(MAX_FRAME) : len_rdata;

  always_comb begin
    state_nxt         = state_r;
    head_nxt          = head_r;
    count_nxt         = count_r;
    open_flag_nxt     = open_flag_r;
    open_client_nxt   = open_client_r;
    open_length_nxt   = open_length_r;
    open_received_nxt = open_received_r;
    open_slot_nxt     = open_slot_r;
    pop_client_nxt    = pop_client_r;
    base_nxt          = base_r;
    idx_nxt           = idx_r;
    mlen_nxt          = mlen_r;
    cmd_pop           = 1'b0;
    emit              = 1'b0;
    e_status          = pcmrq_pkg::ST_OK;
    e_client          = cmd.client;
    e_byte            = '0;
    e_len             = '0;
    e_last            = 1'b1;
    e_notify          = 1'b0;
    e_drop            = 1'b0;
    byte_we           = 1'b0;
    byte_waddr        = slot_base(slot_index(ocidx, open_slot_r)) + AW'(open_received_r);
    byte_re           = 1'b0;
    byte_raddr        = base_r;
    len_we            = 1'b0;
    len_waddr         = slot_index(ocidx, open_slot_r);
    len_wdata         = open_length_r;
    len_re            = 1'b0;
    len_raddr         = slot_index(cidx, h);

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.req != pcmrq_pkg::REQ_DATA) begin
            open_flag_nxt = 1'b0;
          end
          unique case (cmd.req)
            pcmrq_pkg::REQ_DATA: begin
              emit     = 1'b1;
              e_client = open_client_r;
              if (!open_flag_r) begin
                e_status = pcmrq_pkg::ST_NO_OPEN;
              end else begin
                byte_we           = 1'b1;
                open_received_nxt = recv_inc;
                if (recv_inc >= open_length_r) begin
                  len_we           = 1'b1;
                  count_nxt[ocidx] = count_r[ocidx] + CNTW'(1);
                  open_flag_nxt    = 1'b0;
                  e_notify         = 1'b1;
                end
              end
            end
            pcmrq_pkg::REQ_START: begin
              emit = 1'b1;
              if (!cmd.client_ok || !cmd.len_ok) begin
                e_status = pcmrq_pkg::ST_BAD_LEN;
              end else begin
                head_nxt[cidx]    = h1;
                e_drop            = full;
                open_client_nxt   = cmd.client;
                open_length_nxt   = cmd.len;
                open_received_nxt = '0;
                open_slot_nxt     = slot;
                if (cmd.len == '0) begin
                  len_we          = 1'b1;
                  len_waddr       = slot_index(cidx, slot);
                  len_wdata       = cmd.len;
                  count_nxt[cidx] = c1 + CNTW'(1);
                  e_notify        = 1'b1;
                end else begin
                  count_nxt[cidx] = c1;
                  open_flag_nxt   = 1'b1;
                end
              end
            end
            pcmrq_pkg::REQ_POP: begin
              if (!cmd.client_ok || c == '0) begin
                emit     = 1'b1;
                e_status = pcmrq_pkg::ST_EMPTY;
              end else begin
                len_re          = 1'b1;
                head_nxt[cidx]  = ring_inc(h);
                count_nxt[cidx] = c - CNTW'(1);
                pop_client_nxt  = cmd.client;
                base_nxt        = slot_base(slot_index(cidx, h));
                state_nxt       = S_LEN;
              end
            end
            pcmrq_pkg::REQ_NONE: begin
            end
          endcase
        end
      end
      S_LEN: begin
        e_client = pop_client_r;
        if (mlen_cap == '0) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          byte_re   = 1'b1;
          idx_nxt   = LW'(1);
          mlen_nxt  = mlen_cap;
          state_nxt = S_BYTES;
        end
      end
      S_BYTES: begin
        e_client = pop_client_r;
        if (out_free) begin
          emit   = 1'b1;
          e_byte = byte_rdata;
          e_len  = mlen_r;
          e_last = idx_r == mlen_r;
          if (idx_r != mlen_r) begin
            byte_re    = 1'b1;
            byte_raddr = base_r + AW'(idx_r);
            idx_nxt    = idx_r + LW'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    open_length_r   <= open_length_nxt;
    open_received_r <= open_received_nxt;
    open_slot_r     <= open_slot_nxt;
    pop_client_r    <= pop_client_nxt;
    base_r          <= base_nxt;
    idx_r           <= idx_nxt;
    mlen_r          <= mlen_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_client_r <= e_client;
      out_byte_r   <= e_byte;
      out_len_r    <= e_len;
      out_last_r   <= e_last;
      out_notify_r <= e_notify;
      out_drop_r   <= e_drop;
    end
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '{default: '0};
      count_r       <= '{default: '0};
      open_flag_r   <= 1'b0;
      open_client_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      open_flag_r   <= open_flag_nxt;
      open_client_r <= open_client_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  pcmrq_ram #(
    .WIDTH(8),
    .DEPTH(BYTES)
  ) u_byte_ram (
    .clk  (clk),
    .we   (byte_we),
    .waddr(byte_waddr),
    .wdata(cmd.data),
    .re   (byte_re),
    .raddr(byte_raddr),
    .rdata(byte_rdata)
  );

  pcmrq_ram #(
    .WIDTH(LW),
    .DEPTH(SLOTS)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(len_waddr),
    .wdata(len_wdata),
    .re   (len_re),
    .raddr(len_raddr),
    .rdata(len_rdata)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.client_out     = out_client_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.out_len        = out_len_r;
  assign out_ch.last           = out_last_r;
  assign out_ch.notify         = out_notify_r;
  assign out_ch.dropped_oldest = out_drop_r;

endmodule

// ===== sv/per_client_message_ring_queue_core.sv =====
`timescale 1ns / 1ps

// Per-client rings of variable-length messages with drop-oldest overflow. A two-word
// command queue sits between the input and the executor, so input words keep flowing
// while a result waits; an accepted word is registered in the queue and, if the queue was
// empty, reaches the executor on the next cycle. Push start, push data and an empty pop
// each give one result word. A pop of a message works in steps in the executor while the
// output is taken: the pop starts the length read, the S_LEN state starts the first byte
// read, and then one word leaves per cycle in S_BYTES (one word from S_LEN for an empty
// message); the registered reads of the two memories set these steps. Memories need no
// clearing after reset, so the block is ready at once.
module per_client_message_ring_queue_core #(
  parameter int CLIENTS     = pcmrq_pkg::DEF_CLIENTS,
  parameter int QUEUE_DEPTH = pcmrq_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_FRAME   = pcmrq_pkg::DEF_MAX_FRAME
) (
  input  logic          clk,
  input  logic          rst_n,
  pcmrq_in_if.sink      in_ch,
  pcmrq_out_if.source   out_ch
);

  logic            cmd_valid;
  logic            cmd_pop;
  pcmrq_pkg::cmd_t cmd;

  pcmrq_front #(
    .CLIENTS  (CLIENTS),
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  pcmrq_back #(
    .CLIENTS    (CLIENTS),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_FRAME  (MAX_FRAME)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_ch   (out_ch)
  );

  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("executor took a word from an empty command queue");

  a_word_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !cmd_valid) |=> cmd_valid)
    else $error("accepted word did not reach the executor");

  a_notify_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.notify) |->
      (out_ch.status == pcmrq_pkg::ST_OK && out_ch.last && out_ch.out_len == 7'd0))
    else $error("commit notice on a result that is not a final ok word");

  a_byte_only_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_len == 7'd0) |-> out_ch.out_byte == 8'd0)
    else $error("nonzero byte outside a popped message");

endmodule
